// ===== hdl/fmt_pkg.sv =====
package fmt_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned ExpW   = 8;
  localparam int unsigned FracW  = 23;
  localparam int unsigned SigW   = 24;
  localparam int unsigned ProdW  = 48;
  localparam int unsigned HalfW  = 12;
  localparam int unsigned StatW  = 2;
  localparam logic [9:0]  ExpBias  = 10'd127;
  localparam logic [9:0]  ExpLimit = 10'd255;

  typedef enum logic [StatW-1:0] {
    ST_OK        = 2'd0,
    ST_ZERO      = 2'd1,
    ST_OVERFLOW  = 2'd2,
    ST_UNDERFLOW = 2'd3
  } status_t;

endpackage

// ===== hdl/fmt_stream_if.sv =====
interface fmt_stream_if #(
  parameter int unsigned DataW = 32
);
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/float32_multiply_truncating.sv =====
// single-precision multiplier with truncated fraction, no inf/nan handling
// one beat per cycle sustained while the output beat is taken; three register
// stages, the last one being the output register, with the 24x24 significand
// product split into two 24x12 partial products in stage 1 and summed in
// stage 2. the whole pipeline advances together and stalls as a unit when
// the output beat is not taken. status: 0 ok, 1 zero operand, 2 overflow,
// 3 underflow; product is zero whenever status is not ok. in data =
// {operand_a, operand_b}, out data = {product, status}.
module float32_multiply_truncating
  import fmt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  fmt_stream_if.sink   in_s,
  fmt_stream_if.source out_s
);

  logic adv;
  // stage valids: s1 operands decoded, s2 product summed, s3 packed/output
  logic v1_r, v2_r, v3_r;

  assign adv        = !v3_r || out_s.ready;
  assign in_s.ready = adv;

  // stage 1: decode, exponent sum, partial products
  logic [WordW-1:0] a, b;
  logic [SigW-1:0]  ma, mb;
  logic             za, zb;
  logic [9:0]       ex_sum;
  logic             sg1_r;
  logic [1:0]       cls1_r;   // status before normalization
  logic [9:0]       ex1_r;
  logic [35:0]      pp_lo_r, pp_hi_r;

  assign a  = in_s.data[2*WordW-1:WordW];
  assign b  = in_s.data[WordW-1:0];
  assign ma = {1'b1, a[FracW-1:0]};
  assign mb = {1'b1, b[FracW-1:0]};
  assign za = (a[30:23] == '0) && (a[FracW-1:0] == '0);
  assign zb = (b[30:23] == '0) && (b[FracW-1:0] == '0);
  assign ex_sum = {2'b00, a[30:23]} + {2'b00, b[30:23]};

  logic [1:0] cls_nxt;
  always_comb begin
    if (za || zb) cls_nxt = ST_ZERO;
    else if (ex_sum >= ExpLimit + ExpBias) cls_nxt = ST_OVERFLOW;
    else if (ex_sum <= ExpBias) cls_nxt = ST_UNDERFLOW;
    else cls_nxt = ST_OK;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_s.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sg1_r   <= a[31] ^ b[31];
      cls1_r  <= cls_nxt;
      ex1_r   <= ex_sum - ExpBias;
      pp_lo_r <= ma * mb[HalfW-1:0];
      pp_hi_r <= ma * mb[SigW-1:HalfW];
    end
  end

  // stage 2: sum partial products
  logic [ProdW-1:0] p_r;
  logic             sg2_r;
  logic [1:0]       cls2_r;
  logic [9:0]       ex2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r    <= {12'd0, pp_lo_r} + {pp_hi_r, 12'd0};
      sg2_r  <= sg1_r;
      cls2_r <= cls1_r;
      ex2_r  <= ex1_r;
    end
  end

  // stage 3: normalize, final overflow check, pack
  logic [9:0]       ex_n;
  logic [FracW-1:0] frac_n;
  logic [1:0]       st_nxt;
  logic [WordW-1:0] prod_nxt;

  always_comb begin
    if (p_r[ProdW-1]) begin
      ex_n   = ex2_r + 10'd1;
      frac_n = p_r[46:24];
    end else begin
      ex_n   = ex2_r;
      frac_n = p_r[45:23];
    end
    st_nxt   = cls2_r;
    prod_nxt = '0;
    if (cls2_r == ST_OK) begin
      if (ex_n >= ExpLimit) st_nxt = ST_OVERFLOW;
      else prod_nxt = {sg2_r, ex_n[ExpW-1:0], frac_n};
    end
  end

  logic [WordW-1:0] prod_r;
  logic [1:0]       st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (adv) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_r <= prod_nxt;
      st_r   <= st_nxt;
    end
  end

  assign out_s.valid = v3_r;
  assign out_s.data  = {prod_r, st_r};

  // non-ok status always carries a zero product
  a_zero_prod: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (st_r != ST_OK) |-> prod_r == '0) else $error("nonzero product");
  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && !out_s.ready |=> v3_r && $stable(prod_r) && $stable(st_r))
    else $error("result changed under stall");
  // ok results never have exponent 0 or 255
  a_exp: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && (st_r == ST_OK) |-> prod_r[30:23] != 8'hff && prod_r[30:23] != 8'h00)
    else $error("bad exponent");

endmodule

// ===== tb/fmt_mul_checker.sv =====
module fmt_mul_checker
  import fmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [63:0] in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [33:0] out_data,
  output int          fail_cnt,
  output int          pending_cnt
);

  typedef struct packed {
    logic [31:0] product;
    status_t     status;
  } mul_result_t;

  mul_result_t product_q[$];

  function automatic logic is_zero_word(logic [31:0] w);
    return w[30:23] == '0 && w[22:0] == '0;
  endfunction

  // truncating multiply, hidden one always prepended
  function automatic mul_result_t mul_trunc(logic [31:0] a, logic [31:0] b);
    mul_result_t r;
    logic [47:0] sig;
    logic [22:0] frac;
    int          ex;
    r.product = '0;
    r.status  = ST_OK;
    if (is_zero_word(a) || is_zero_word(b)) begin
      r.status = ST_ZERO;
      return r;
    end
    ex = int'(a[30:23]) + int'(b[30:23]) - 127;
    if (ex >= 255) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    if (ex <= 0) begin
      r.status = ST_UNDERFLOW;
      return r;
    end
    sig = {24'd0, 1'b1, a[22:0]} * {24'd0, 1'b1, b[22:0]};
    if (sig[47]) begin
      frac = sig[46:24];
      ex++;
    end else begin
      frac = sig[45:23];
    end
    if (ex >= 255) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    r.product = {a[31] ^ b[31], ex[7:0], frac};
    return r;
  endfunction

  assign pending_cnt = product_q.size();

  always @(posedge clk) begin
    mul_result_t got, want;
    if (!rst_n) begin
      fail_cnt = 0;
      product_q.delete();
    end else begin
      if (in_valid && in_ready)
        product_q.push_back(mul_trunc(in_data[63:32], in_data[31:0]));
      if (out_valid && out_ready) begin
        got = out_data;
        if (product_q.size() == 0) begin
          $display("%0t: unexpected beat %h", $time, got);
          fail_cnt++;
        end else begin
          want = product_q.pop_front();
          if (got.product !== want.product) begin
            $display("%0t: product expected %h actual %h", $time, want.product, got.product);
            fail_cnt++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_cnt++;
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb_top.sv =====
module tb_top
  import fmt_pkg::*;
;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_cnt;
  int   pending_cnt;

  always #10 clk = ~clk;

  fmt_stream_if #(.DataW(64)) mul_in ();
  fmt_stream_if #(.DataW(34)) mul_out ();

  float32_multiply_truncating dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_s  (mul_in.sink),
    .out_s (mul_out.source)
  );

  fmt_mul_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (mul_in.valid),
    .in_ready    (mul_in.ready),
    .in_data     (mul_in.data),
    .out_valid   (mul_out.valid),
    .out_ready   (mul_out.ready),
    .out_data    (mul_out.data),
    .fail_cnt    (fail_cnt),
    .pending_cnt (pending_cnt)
  );

  initial begin
    mul_in.valid  = 1'b0;
    mul_in.data   = '0;
    mul_out.ready = 1'b0;
  end

  // receiver stall pattern: phases of always-ready, light and heavy stalls
  initial begin
    int phase_len;
    int mode;
    @(posedge clk iff rst_n);
    forever begin
      phase_len = $urandom_range(5, 60);
      mode = $urandom_range(0, 2);
      repeat (phase_len) begin
        @(posedge clk);
        case (mode)
          0: mul_out.ready <= 1'b1;
          1: mul_out.ready <= ($urandom_range(0, 3) != 0);
          default: mul_out.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // pick an exponent field, biased toward the edges where status flips
  function automatic logic [7:0] pick_exp();
    case ($urandom_range(0, 5))
      0: return 8'($urandom_range(0, 3));
      1: return 8'($urandom_range(252, 255));
      2: return 8'($urandom_range(120, 135));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_operand();
    logic [22:0] frac;
    case ($urandom_range(0, 3))
      0: frac = '0;
      1: frac = '1;
      default: frac = 23'($urandom);
    endcase
    if ($urandom_range(0, 19) == 0)
      return {1'($urandom), 31'd0};
    return {1'($urandom), pick_exp(), frac};
  endfunction

  // one beat; valid stays high while the burst goes on
  task automatic send_beat(input logic [31:0] a, input logic [31:0] b, input bit keep);
    mul_in.valid <= 1'b1;
    mul_in.data  <= {a, b};
    @(posedge clk);
    while (!mul_in.ready) @(posedge clk);
    if (!keep) mul_in.valid <= 1'b0;
  endtask

  localparam int NumDirected = 18;
  logic [31:0] dir_a [NumDirected] = '{
    32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'h3fff_ffff, 32'h7f80_0000,
    32'h7fff_ffff, 32'h4000_0000, 32'h0000_0001, 32'h0080_0000, 32'h3f80_0000,
    32'hbfc0_0000, 32'h7f00_0000, 32'h5f80_0000, 32'h5fff_ffff, 32'h2000_0000,
    32'hffff_ffff, 32'h3f80_0000, 32'h0040_0000};
  logic [31:0] dir_b [NumDirected] = '{
    32'h3f80_0000, 32'h4000_0000, 32'h0000_0000, 32'h3fff_ffff, 32'h3f80_0000,
    32'h7fff_ffff, 32'h4000_0000, 32'h3f80_0000, 32'h3f80_0000, 32'h8080_0000,
    32'h3fc0_0000, 32'h4000_0000, 32'h5f00_0000, 32'h5fff_ffff, 32'h1f00_0000,
    32'hffff_ffff, 32'hbf80_0000, 32'h7f00_0000};

  initial begin
    int sent;
    int burst;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zeros, signed zero, overflow edge, underflow edge, subnormals,
    // inf/nan patterns; runs straight into the first random burst
    for (int i = 0; i < NumDirected; i++)
      send_beat(dir_a[i], dir_b[i], 1'b1);

    sent = 0;
    while (sent < 700) begin
      burst = $urandom_range(1, 25);
      for (int j = 0; j < burst; j++)
        send_beat(pick_operand(), pick_operand(), j != burst - 1);
      sent += burst;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end

    while (pending_cnt != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_cnt == 0)
      $display("** float32_multiply_truncating: PASSED **");
    else
      $display("** float32_multiply_truncating: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("** float32_multiply_truncating: FAILED **");
    $finish;
  end

endmodule
